@@ hw/rtl/bspd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bspd_pkg
// Shared types and fixed constants of the battery status packet decoder.
// ----------------------------------------------------------------------------
package bspd_pkg;

   typedef logic        [7:0]  byte_type;
   typedef logic        [1:0]  charge_type;
   typedef logic        [10:0] volt_type;
   typedef logic signed [11:0] diff_type;
   typedef logic signed [2:0]  level_type;
   typedef logic        [6:0]  miss_type;

   // charge state codes
   localparam charge_type CHARGE_IDLE = 2'd0;
   localparam charge_type CHARGE_DONE = 2'd3;

   // status byte layout
   localparam byte_type STATUS_CHARGE_MASK = 8'h07;
   localparam byte_type STATUS_MODE_MASK   = 8'h08;

   // grades
   localparam level_type LEVEL_NONE = -3'sd1;
   localparam level_type LEVEL_0    = 3'sd0;
   localparam level_type LEVEL_1    = 3'sd1;
   localparam level_type LEVEL_2    = 3'sd2;
   localparam level_type LEVEL_3    = 3'sd3;

   // controller cell thresholds, 10 mV units
   localparam volt_type CELL1_TH3 = 11'd370;
   localparam volt_type CELL1_TH2 = 11'd355;
   localparam volt_type CELL1_TH1 = 11'd340;
   localparam volt_type CELL1_TH0 = 11'd330;

   // two-cell pack thresholds, 10 mV units
   localparam volt_type PACK_TH3 = 11'd740;
   localparam volt_type PACK_TH2 = 11'd720;
   localparam volt_type PACK_TH1 = 11'd700;
   localparam volt_type PACK_TH0 = 11'd600;

   // per-cell override limits
   localparam volt_type CELL_EMPTY = 11'd300;
   localparam volt_type CELL_WEAK  = 11'd350;

   localparam miss_type MISS_HELD = 7'd99;

endpackage : bspd_pkg
`default_nettype wire

@@ hw/rtl/bspd_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bspd_req_if
// Request channel: one received packet or one receive timeout per request.
// ----------------------------------------------------------------------------
interface bspd_req_if;
   import bspd_pkg::*;

   logic     valid;
   logic     ready;
   logic     packet_received;
   byte_type status_byte;
   byte_type cell1_byte;
   byte_type pack2_low_byte;
   byte_type pack2_total_byte;
   byte_type pack3_low_byte;
   byte_type pack3_total_byte;

   modport source (
      output valid, packet_received, status_byte, cell1_byte,
             pack2_low_byte, pack2_total_byte, pack3_low_byte, pack3_total_byte,
      input  ready
   );

   modport sink (
      input  valid, packet_received, status_byte, cell1_byte,
             pack2_low_byte, pack2_total_byte, pack3_low_byte, pack3_total_byte,
      output ready
   );

endinterface : bspd_req_if
`default_nettype wire

@@ hw/rtl/bspd_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bspd_rsp_if
// Response channel: the decoded status record after each request.
// ----------------------------------------------------------------------------
interface bspd_rsp_if;
   import bspd_pkg::*;

   logic       valid;
   logic       ready;
   charge_type charge_state;
   logic       single_pack_mode;
   volt_type   cell1_voltage;
   volt_type   pack2_low_voltage;
   diff_type   pack2_high_voltage;
   volt_type   pack3_low_voltage;
   diff_type   pack3_high_voltage;
   level_type  level1;
   level_type  level2;
   level_type  level3;
   miss_type   miss_count;

   modport source (
      output valid, charge_state, single_pack_mode, cell1_voltage,
             pack2_low_voltage, pack2_high_voltage, pack3_low_voltage,
             pack3_high_voltage, level1, level2, level3, miss_count,
      input  ready
   );

   modport sink (
      input  valid, charge_state, single_pack_mode, cell1_voltage,
             pack2_low_voltage, pack2_high_voltage, pack3_low_voltage,
             pack3_high_voltage, level1, level2, level3, miss_count,
      output ready
   );

endinterface : bspd_rsp_if
`default_nettype wire

@@ hw/rtl/battery_status_packet_decoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// battery_status_packet_decoder_core
// Decodes charger status packets and receive timeouts into a held status
// record with scaled voltages, battery grades and a miss counter.
// ----------------------------------------------------------------------------
// Each request is a received packet or a receive timeout; each request yields
// exactly one response carrying the held record after the update. Requests
// pass the request register, then the record register, which doubles as the
// response register, and one request is accepted every cycle as long as
// the response side keeps up. A stalled response leaves room for one more
// request in the request register. The held record resets to charge state
// idle, single pack mode set, all voltages zero, all grades -1 and no misses.
// A packet clears the miss counter; MISS_LIMIT consecutive timeouts are
// tolerated, the next one forces the counter to 99, the charge state to idle
// and all grades to -1. Voltages and the mode bit survive timeouts.
// ----------------------------------------------------------------------------
module battery_status_packet_decoder_core #(
   parameter int MISS_LIMIT = 3
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bspd_req_if.sink    req_bus,
   bspd_rsp_if.source  rsp_bus
);
   import bspd_pkg::*;

   // -------------------------------------------------------------------------
   // grading helpers
   // -------------------------------------------------------------------------
   function automatic level_type grade_cell1(input volt_type v);
      level_type g;
      if (v > CELL1_TH3)      g = LEVEL_3;
      else if (v > CELL1_TH2) g = LEVEL_2;
      else if (v > CELL1_TH1) g = LEVEL_1;
      else if (v > CELL1_TH0) g = LEVEL_0;
      else                    g = LEVEL_NONE;
      return g;
   endfunction

   // grade from the pack total, then override it on a weak or empty cell;
   // the upper cell is signed since a bad total can undercut the lower cell
   function automatic level_type grade_pack(input volt_type total, input volt_type low,
                                            input diff_type high);
      level_type g;
      if (total > PACK_TH3)      g = LEVEL_3;
      else if (total > PACK_TH2) g = LEVEL_2;
      else if (total > PACK_TH1) g = LEVEL_1;
      else if (total > PACK_TH0) g = LEVEL_0;
      else                       g = LEVEL_NONE;
      if (low <= CELL_EMPTY)                          g = LEVEL_NONE;
      else if (high <= $signed({1'b0, CELL_EMPTY}))   g = LEVEL_NONE;
      else if (low <= CELL_WEAK)                      g = LEVEL_0;
      else if (high <= $signed({1'b0, CELL_WEAK}))    g = LEVEL_0;
      return g;
   endfunction

   // 50 mV steps to 10 mV units: x*5 = x*4 + x
   function automatic volt_type scale5(input byte_type b);
      return {1'b0, b, 2'b00} + {3'b000, b};
   endfunction

   // -------------------------------------------------------------------------
   // request register
   // -------------------------------------------------------------------------
   logic     in_valid_ff, in_valid_in;
   logic     in_pkt_ff;
   byte_type in_status_ff, in_cell1_ff, in_p2_low_ff, in_p2_tot_ff;
   byte_type in_p3_low_ff, in_p3_tot_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic advance;     // request register moves into the record
   logic req_take;    // new request accepted this cycle

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_pkt_ff    <= req_bus.packet_received;
         in_status_ff <= req_bus.status_byte;
         in_cell1_ff  <= req_bus.cell1_byte;
         in_p2_low_ff <= req_bus.pack2_low_byte;
         in_p2_tot_ff <= req_bus.pack2_total_byte;
         in_p3_low_ff <= req_bus.pack3_low_byte;
         in_p3_tot_ff <= req_bus.pack3_total_byte;
      end
   end

   // -------------------------------------------------------------------------
   // decode
   // -------------------------------------------------------------------------
   volt_type   v1, v2, t2, v4, t3;
   diff_type   v3, v5;
   byte_type   cs_raw;
   charge_type cs_cap;
   logic       mode_new;
   miss_type   miss_next;

   charge_type cs_ff, cs_in;
   logic       mode_ff, mode_in;
   volt_type   v1_ff, v1_in, v2_ff, v2_in, v4_ff, v4_in;
   diff_type   v3_ff, v3_in, v5_ff, v5_in;
   level_type  lv1_ff, lv1_in, lv2_ff, lv2_in, lv3_ff, lv3_in;
   miss_type   miss_ff, miss_in;

   assign v1 = scale5(in_cell1_ff);
   assign v2 = scale5(in_p2_low_ff);
   assign t2 = scale5(in_p2_tot_ff);
   assign v4 = scale5(in_p3_low_ff);
   assign t3 = scale5(in_p3_tot_ff);
   assign v3 = $signed({1'b0, t2}) - $signed({1'b0, v2});
   assign v5 = $signed({1'b0, t3}) - $signed({1'b0, v4});

   assign cs_raw   = in_status_ff & STATUS_CHARGE_MASK;
   assign cs_cap   = (cs_raw > 8'(CHARGE_DONE)) ? CHARGE_DONE : cs_raw[1:0];
   assign mode_new = |(in_status_ff & STATUS_MODE_MASK);
   assign miss_next = miss_ff + 7'd1;   // at most 100, fits

   always_comb begin
      cs_in   = cs_ff;
      mode_in = mode_ff;
      v1_in   = v1_ff;
      v2_in   = v2_ff;
      v3_in   = v3_ff;
      v4_in   = v4_ff;
      v5_in   = v5_ff;
      lv1_in  = lv1_ff;
      lv2_in  = lv2_ff;
      lv3_in  = lv3_ff;
      miss_in = miss_ff;
      if (advance) begin
         if (in_pkt_ff) begin
            miss_in = '0;
            cs_in   = cs_cap;
            mode_in = mode_new;
            v1_in   = v1;
            v2_in   = v2;
            v3_in   = v3;
            v4_in   = v4;
            v5_in   = v5;
            lv1_in  = grade_cell1(v1);
            lv2_in  = grade_pack(t2, v2, v3);
            lv3_in  = mode_new ? LEVEL_NONE : grade_pack(t3, v4, v5);
         end else if (miss_next > 7'(MISS_LIMIT)) begin
            // link lost: drop the charge state and grades
            miss_in = MISS_HELD;
            cs_in   = CHARGE_IDLE;
            lv1_in  = LEVEL_NONE;
            lv2_in  = LEVEL_NONE;
            lv3_in  = LEVEL_NONE;
         end else begin
            miss_in = miss_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance)            rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   // -------------------------------------------------------------------------
   // held record / response register
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cs_ff        <= CHARGE_IDLE;
         mode_ff      <= 1'b1;
         v1_ff        <= '0;
         v2_ff        <= '0;
         v3_ff        <= '0;
         v4_ff        <= '0;
         v5_ff        <= '0;
         lv1_ff       <= LEVEL_NONE;
         lv2_ff       <= LEVEL_NONE;
         lv3_ff       <= LEVEL_NONE;
         miss_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cs_ff        <= cs_in;
         mode_ff      <= mode_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         v5_ff        <= v5_in;
         lv1_ff       <= lv1_in;
         lv2_ff       <= lv2_in;
         lv3_ff       <= lv3_in;
         miss_ff      <= miss_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.charge_state       = cs_ff;
   assign rsp_bus.single_pack_mode   = mode_ff;
   assign rsp_bus.cell1_voltage      = v1_ff;
   assign rsp_bus.pack2_low_voltage  = v2_ff;
   assign rsp_bus.pack2_high_voltage = v3_ff;
   assign rsp_bus.pack3_low_voltage  = v4_ff;
   assign rsp_bus.pack3_high_voltage = v5_ff;
   assign rsp_bus.level1             = lv1_ff;
   assign rsp_bus.level2             = lv2_ff;
   assign rsp_bus.level3             = lv3_ff;
   assign rsp_bus.miss_count         = miss_ff;

`ifndef SYNTH
   // counter is either within the tolerated run or pinned
   a_miss_range: assert property (@(posedge clock) disable iff (reset)
      (miss_ff <= 7'(MISS_LIMIT)) || (miss_ff == MISS_HELD))
      else $error("miss counter out of range");

   // a packet always clears the miss counter
   a_pkt_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_pkt_ff) |=> (miss_ff == '0))
      else $error("packet did not clear miss counter");

   // pinned counter means charge state and grades were dropped
   a_lost_clear: assert property (@(posedge clock) disable iff (reset)
      (miss_ff == MISS_HELD) |-> (cs_ff == CHARGE_IDLE && lv1_ff == LEVEL_NONE &&
                                  lv2_ff == LEVEL_NONE && lv3_ff == LEVEL_NONE))
      else $error("record not cleared after link loss");

   // pack three is never graded in single pack mode
   a_single_pack: assert property (@(posedge clock) disable iff (reset)
      mode_ff |-> (lv3_ff == LEVEL_NONE))
      else $error("pack three graded in single pack mode");

   // record only changes when a request moves in
   a_record_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(miss_ff) && $stable(v1_ff) && $stable(lv2_ff)))
      else $error("record changed without a request");
`endif

endmodule : battery_status_packet_decoder_core
`default_nettype wire
